@@ hw/rtl/ptw_pkg.sv @@
// ptw_pkg: field widths, status codes, register indexes and entry layouts
// for the two-level page table walker. Depends on nothing; used by the
// walker and its port checker.
package ptw_pkg;

   localparam int ENTRIES_PER_TABLE_DEF = 16;
   localparam int MAX_FRAMES_DEF        = 256;
   localparam int MAX_PROCS_DEF         = 16;

   localparam int PID_W      = 4;
   localparam int PAGE_W     = 8;
   localparam int STATUS_W   = 2;
   localparam int FRAME_W    = 8;
   localparam int REF_W      = 8;
   localparam int CNT9_W     = 9;
   localparam int REFS_W     = 16;
   localparam int NPROC_W    = 5;
   localparam int TFRAMES_W  = 9;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 9;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_OOM     = 2'd1,
      ST_HALTED  = 2'd2,
      ST_BAD_PID = 2'd3
   } status_type;

   localparam logic [CSR_ADDR_W-1:0] CSR_NUM_PROCESSES = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_TOTAL_FRAMES  = 1'd1;

   typedef struct packed {
      logic               valid;
      logic [FRAME_W-1:0] frame;
      logic [REF_W-1:0]   refs;
   } pte_type;

   typedef struct packed {
      logic [CNT9_W-1:0] faults;
      logic [CNT9_W-1:0] frames;
      logic [REFS_W-1:0] refs_done;
   } proc_cnt_type;

endpackage

@@ hw/rtl/ptw_ram.sv @@
// ptw_ram: generic simple dual-port RAM, one write and one registered read
// per cycle. Stand-alone; used by the page table walker.
module ptw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/two_level_page_table_walker.sv @@
// two_level_page_table_walker: sequencer, address unit and counters of the
// demand-paging walker. Depends on ptw_pkg and ptw_ram.
//
// Usage:
//   csr_*  : write port, csr_index 0 = num_processes, 1 = total_frames. Every
//            write starts a new run: all tables and counters go back to their
//            start values, which takes a clearing pass (see below).
//   req_*  : one page reference (process id, virtual page) per request.
//   rsp_*  : one result per request, held in an output register until taken.
// Timing: a request walks L1 read, L1 check/update, L2 read, L2 check/update
//   and result load, in that order, up to rsp_valid; a walk that ends at the
//   L1 check (halted, bad process id or out of memory there) goes straight
//   to result load. The walker takes one request at a time; the sequencer
//   and the single PTE RAM port pair hold it to that.
// A new request is taken while the previous result still waits in the output
//   register; if the receiver stalls, the next walk halts before loading its
//   result until the register frees.
// Reset (and any csr write) starts a clearing pass over the PTE and counter
//   RAMs that sweeps max(MAX_FRAMES*ENTRIES_PER_TABLE, MAX_PROCS) addresses
//   (4096 by default), during which req_ready stays low.
module two_level_page_table_walker #(
   parameter int ENTRIES_PER_TABLE = ptw_pkg::ENTRIES_PER_TABLE_DEF,
   parameter int MAX_FRAMES        = ptw_pkg::MAX_FRAMES_DEF,
   parameter int MAX_PROCS         = ptw_pkg::MAX_PROCS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [ptw_pkg::CSR_ADDR_W-1:0]  csr_index,
   input  logic [ptw_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [ptw_pkg::PID_W-1:0]       req_process_id,
   input  logic [ptw_pkg::PAGE_W-1:0]      req_virtual_page,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [ptw_pkg::STATUS_W-1:0]    rsp_status,
   output logic                            rsp_l1_was_hit,
   output logic                            rsp_l2_was_hit,
   output logic [ptw_pkg::FRAME_W-1:0]     rsp_l2_table_frame,
   output logic [ptw_pkg::FRAME_W-1:0]     rsp_data_frame,
   output logic [ptw_pkg::REF_W-1:0]       rsp_ref_count,
   output logic [ptw_pkg::CNT9_W-1:0]      rsp_proc_faults,
   output logic [ptw_pkg::CNT9_W-1:0]      rsp_proc_frames,
   output logic [ptw_pkg::REFS_W-1:0]      rsp_proc_refs_done,
   output logic [ptw_pkg::CNT9_W-1:0]      rsp_frames_used
);
   import ptw_pkg::*;

   localparam int DEPTH     = MAX_FRAMES * ENTRIES_PER_TABLE;
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int ROW_W     = $clog2(MAX_FRAMES);
   localparam int IDX_W     = $clog2(ENTRIES_PER_TABLE);
   localparam int PROC_W    = MAX_PROCS > 1 ? $clog2(MAX_PROCS) : 1;
   localparam int CLEAR_LEN = DEPTH > MAX_PROCS ? DEPTH : MAX_PROCS;
   localparam int SWEEP_W   = $clog2(CLEAR_LEN);
   localparam int CMP_W     = SWEEP_W + NPROC_W + 1;
   localparam int PAGES     = 2 ** PAGE_W;
   localparam int PTE_W     = $bits(pte_type);
   localparam int CNT_W     = $bits(proc_cnt_type);

   typedef logic [IDX_W-1:0] idx_tab_type [PAGES];

   // page split tables: l1 index wraps modulo the table size
   function automatic idx_tab_type build_tab(input logic want_l1);
      idx_tab_type tab;
      int quo;
      int rem;
      quo = 0;
      rem = 0;
      for (int p = 0; p < PAGES; p++) begin
         tab[p] = want_l1 ? IDX_W'(quo) : IDX_W'(rem);
         rem = rem + 1;
         if (rem == ENTRIES_PER_TABLE) begin
            rem = 0;
            quo = quo + 1;
            if (quo == ENTRIES_PER_TABLE) begin
               quo = 0;
            end
         end
      end
      return tab;
   endfunction

   localparam idx_tab_type L1_TAB = build_tab(1'b1);
   localparam idx_tab_type L2_TAB = build_tab(1'b0);

   function automatic logic [CNT9_W-1:0] sat_inc9(input logic [CNT9_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_L1_RD,
      S_L1_CHK,
      S_L2_RD,
      S_L2_CHK,
      S_RESP
   } state_type;

   state_type               state_ff, state_in;
   logic [SWEEP_W-1:0]      sweep_ff, sweep_in;
   logic [NPROC_W-1:0]      eff_procs_ff, eff_procs_in;
   logic [TFRAMES_W-1:0]    eff_frames_ff, eff_frames_in;
   logic [CNT9_W-1:0]       next_free_ff, next_free_in;
   logic                    halted_ff, halted_in;
   logic [PID_W-1:0]        pid_ff, pid_in;
   logic [PAGE_W-1:0]       page_ff, page_in;
   logic [ADDR_W-1:0]       pte_addr_ff, pte_addr_in;
   status_type              st_ff, st_in;
   logic                    l1hit_ff, l1hit_in;
   logic                    l2hit_ff, l2hit_in;
   logic [FRAME_W-1:0]      l2base_ff, l2base_in;
   logic [FRAME_W-1:0]      dframe_ff, dframe_in;
   logic [REF_W-1:0]        ref_ff, ref_in;
   proc_cnt_type            cnt_ff, cnt_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   status_type              rsp_status_ff, rsp_status_in;
   logic                    rsp_l1hit_ff, rsp_l1hit_in;
   logic                    rsp_l2hit_ff, rsp_l2hit_in;
   logic [FRAME_W-1:0]      rsp_l2base_ff, rsp_l2base_in;
   logic [FRAME_W-1:0]      rsp_dframe_ff, rsp_dframe_in;
   logic [REF_W-1:0]        rsp_ref_ff, rsp_ref_in;
   proc_cnt_type            rsp_cnt_ff, rsp_cnt_in;
   logic [CNT9_W-1:0]       rsp_used_ff, rsp_used_in;

   // shared address unit: row * ENTRIES_PER_TABLE + index
   logic [ROW_W-1:0]        au_row;
   logic [IDX_W-1:0]        au_idx;
   logic [ADDR_W-1:0]       au_addr;

   logic                    pte_we;
   logic [ADDR_W-1:0]       pte_wr_addr;
   pte_type                 pte_wr_data;
   logic [ADDR_W-1:0]       pte_rd_addr;
   pte_type                 pte_rd_data;

   logic                    cnt_we;
   logic [PROC_W-1:0]       cnt_wr_addr;
   proc_cnt_type            cnt_wr_data;
   proc_cnt_type            cnt_rd_data;

   logic [REF_W-1:0]        ref_plus;
   logic                    alloc_fail;
   logic                    rsp_free;
   logic [NPROC_W-1:0]      csr_procs;
   logic [TFRAMES_W-1:0]    csr_frames;

   assign au_row  = (state_ff == S_L1_RD) ? ROW_W'(pid_ff) : ROW_W'(l2base_ff);
   assign au_idx  = (state_ff == S_L1_RD) ? L1_TAB[page_ff] : L2_TAB[page_ff];
   assign au_addr = ADDR_W'(au_row) * ADDR_W'(ENTRIES_PER_TABLE) + ADDR_W'(au_idx);

   assign pte_rd_addr = au_addr;
   assign ref_plus    = pte_rd_data.refs + 1'b1;
   assign alloc_fail  = next_free_ff >= CNT9_W'(eff_frames_ff);
   assign rsp_free    = !rsp_valid_ff || rsp_ready;

   assign csr_procs  = (32'(csr_wdata[NPROC_W-1:0]) > MAX_PROCS) ?
                       NPROC_W'(MAX_PROCS) : csr_wdata[NPROC_W-1:0];
   assign csr_frames = (32'(csr_wdata[TFRAMES_W-1:0]) > MAX_FRAMES) ?
                       TFRAMES_W'(MAX_FRAMES) : csr_wdata[TFRAMES_W-1:0];

   always_comb begin
      state_in      = state_ff;
      sweep_in      = sweep_ff;
      eff_procs_in  = eff_procs_ff;
      eff_frames_in = eff_frames_ff;
      next_free_in  = next_free_ff;
      halted_in     = halted_ff;
      pid_in        = pid_ff;
      page_in       = page_ff;
      pte_addr_in   = pte_addr_ff;
      st_in         = st_ff;
      l1hit_in      = l1hit_ff;
      l2hit_in      = l2hit_ff;
      l2base_in     = l2base_ff;
      dframe_in     = dframe_ff;
      ref_in        = ref_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_l1hit_in  = rsp_l1hit_ff;
      rsp_l2hit_in  = rsp_l2hit_ff;
      rsp_l2base_in = rsp_l2base_ff;
      rsp_dframe_in = rsp_dframe_ff;
      rsp_ref_in    = rsp_ref_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      rsp_used_in   = rsp_used_ff;

      pte_we      = 1'b0;
      pte_wr_addr = pte_addr_ff;
      pte_wr_data = '0;
      cnt_we      = 1'b0;
      cnt_wr_addr = PROC_W'(pid_ff);
      cnt_wr_data = cnt_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            pte_we      = {1'b0, sweep_ff} < (SWEEP_W + 1)'(DEPTH);
            pte_wr_addr = sweep_ff[ADDR_W-1:0];
            cnt_we      = {1'b0, sweep_ff} < (SWEEP_W + 1)'(MAX_PROCS);
            cnt_wr_addr = sweep_ff[PROC_W-1:0];
            cnt_wr_data = '0;
            // each process starts owning its l1 table frame
            if (CMP_W'(sweep_ff) < CMP_W'(eff_procs_ff)) begin
               cnt_wr_data.frames = CNT9_W'(1);
            end
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == SWEEP_W'(CLEAR_LEN - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               pid_in    = req_process_id;
               page_in   = req_virtual_page;
               st_in     = ST_OK;
               l1hit_in  = 1'b0;
               l2hit_in  = 1'b0;
               l2base_in = '0;
               dframe_in = '0;
               ref_in    = '0;
               cnt_in    = '0;
               state_in  = S_L1_RD;
            end
         end
         S_L1_RD: begin
            pte_addr_in = au_addr;
            state_in    = S_L1_CHK;
         end
         S_L1_CHK: begin
            state_in = S_L2_RD;
            if (halted_ff) begin
               st_in    = ST_HALTED;
               state_in = S_RESP;
            end else if ({1'b0, pid_ff} >= eff_procs_ff) begin
               st_in    = ST_BAD_PID;
               state_in = S_RESP;
            end else begin
               cnt_in = cnt_rd_data;
               if (TFRAMES_W'(pid_ff) >= eff_frames_ff) begin
                  // no frame left for this process's l1 table
                  st_in     = ST_OOM;
                  halted_in = 1'b1;
                  state_in  = S_RESP;
               end else if (pte_rd_data.valid) begin
                  l1hit_in  = 1'b1;
                  l2base_in = pte_rd_data.frame;
               end else if (alloc_fail) begin
                  st_in     = ST_OOM;
                  halted_in = 1'b1;
                  state_in  = S_RESP;
               end else begin
                  // new l2 table; its row is still clear from the run start
                  pte_we             = 1'b1;
                  pte_wr_data.valid  = 1'b1;
                  pte_wr_data.frame  = next_free_ff[FRAME_W-1:0];
                  l2base_in          = next_free_ff[FRAME_W-1:0];
                  next_free_in       = next_free_ff + 1'b1;
                  cnt_in.frames      = sat_inc9(cnt_rd_data.frames);
                  cnt_in.faults      = sat_inc9(cnt_rd_data.faults);
               end
            end
         end
         S_L2_RD: begin
            pte_addr_in = au_addr;
            state_in    = S_L2_CHK;
         end
         S_L2_CHK: begin
            state_in = S_RESP;
            if (pte_rd_data.valid) begin
               pte_we            = 1'b1;
               pte_wr_data.valid = 1'b1;
               pte_wr_data.frame = pte_rd_data.frame;
               pte_wr_data.refs  = ref_plus;
               l2hit_in          = 1'b1;
               dframe_in         = pte_rd_data.frame;
               ref_in            = ref_plus;
               if (cnt_ff.refs_done != '1) begin
                  cnt_in.refs_done = cnt_ff.refs_done + 1'b1;
               end
            end else if (alloc_fail) begin
               st_in     = ST_OOM;
               halted_in = 1'b1;
            end else begin
               pte_we            = 1'b1;
               pte_wr_data.valid = 1'b1;
               pte_wr_data.frame = next_free_ff[FRAME_W-1:0];
               pte_wr_data.refs  = REF_W'(1);
               dframe_in         = next_free_ff[FRAME_W-1:0];
               ref_in            = REF_W'(1);
               next_free_in      = next_free_ff + 1'b1;
               cnt_in.frames     = sat_inc9(cnt_ff.frames);
               cnt_in.faults     = sat_inc9(cnt_ff.faults);
               if (cnt_ff.refs_done != '1) begin
                  cnt_in.refs_done = cnt_ff.refs_done + 1'b1;
               end
            end
         end
         S_RESP: begin
            if (rsp_free) begin
               // counters persist also on out of memory (l1 allocation kept)
               cnt_we        = (st_ff == ST_OK) || (st_ff == ST_OOM);
               rsp_valid_in  = 1'b1;
               rsp_status_in = st_ff;
               rsp_l1hit_in  = l1hit_ff;
               rsp_l2hit_in  = l2hit_ff;
               rsp_l2base_in = l2base_ff;
               rsp_dframe_in = dframe_ff;
               rsp_ref_in    = ref_ff;
               rsp_cnt_in    = cnt_ff;
               rsp_used_in   = ((st_ff == ST_OK) || (st_ff == ST_OOM)) ?
                               next_free_ff : '0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase

      // a register write starts a new run
      if (csr_we) begin
         if (csr_index == CSR_NUM_PROCESSES) begin
            eff_procs_in = csr_procs;
            next_free_in = CNT9_W'(csr_procs);
         end else begin
            eff_frames_in = csr_frames;
            next_free_in  = CNT9_W'(eff_procs_ff);
         end
         halted_in = 1'b0;
         sweep_in  = '0;
         state_in  = S_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         sweep_ff      <= '0;
         eff_procs_ff  <= NPROC_W'(1);
         eff_frames_ff <= TFRAMES_W'(MAX_FRAMES);
         next_free_ff  <= CNT9_W'(1);
         halted_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sweep_ff      <= sweep_in;
         eff_procs_ff  <= eff_procs_in;
         eff_frames_ff <= eff_frames_in;
         next_free_ff  <= next_free_in;
         halted_ff     <= halted_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      pid_ff        <= pid_in;
      page_ff       <= page_in;
      pte_addr_ff   <= pte_addr_in;
      st_ff         <= st_in;
      l1hit_ff      <= l1hit_in;
      l2hit_ff      <= l2hit_in;
      l2base_ff     <= l2base_in;
      dframe_ff     <= dframe_in;
      ref_ff        <= ref_in;
      cnt_ff        <= cnt_in;
      rsp_status_ff <= rsp_status_in;
      rsp_l1hit_ff  <= rsp_l1hit_in;
      rsp_l2hit_ff  <= rsp_l2hit_in;
      rsp_l2base_ff <= rsp_l2base_in;
      rsp_dframe_ff <= rsp_dframe_in;
      rsp_ref_ff    <= rsp_ref_in;
      rsp_cnt_ff    <= rsp_cnt_in;
      rsp_used_ff   <= rsp_used_in;
   end

   ptw_ram #(
      .WIDTH (PTE_W),
      .DEPTH (DEPTH)
   ) u_pte_ram (
      .clock   (clock),
      .wr_en   (pte_we),
      .wr_addr (pte_wr_addr),
      .wr_data (pte_wr_data),
      .rd_addr (pte_rd_addr),
      .rd_data (pte_rd_data)
   );

   ptw_ram #(
      .WIDTH (CNT_W),
      .DEPTH (MAX_PROCS)
   ) u_cnt_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_wr_addr),
      .wr_data (cnt_wr_data),
      .rd_addr (PROC_W'(pid_ff)),
      .rd_data (cnt_rd_data)
   );

   assign req_ready          = (state_ff == S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_l1_was_hit     = rsp_l1hit_ff;
   assign rsp_l2_was_hit     = rsp_l2hit_ff;
   assign rsp_l2_table_frame = rsp_l2base_ff;
   assign rsp_data_frame     = rsp_dframe_ff;
   assign rsp_ref_count      = rsp_ref_ff;
   assign rsp_proc_faults    = rsp_cnt_ff.faults;
   assign rsp_proc_frames    = rsp_cnt_ff.frames;
   assign rsp_proc_refs_done = rsp_cnt_ff.refs_done;
   assign rsp_frames_used    = rsp_used_ff;

endmodule

@@ hw/rtl/ptw_checker.sv @@
// ptw_checker: port-level assertions for the page table walker, bound to
// the top level below. Depends on ptw_pkg.
module ptw_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            csr_we,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [ptw_pkg::STATUS_W-1:0]    rsp_status,
   input logic                            rsp_l1_was_hit,
   input logic                            rsp_l2_was_hit,
   input logic [ptw_pkg::FRAME_W-1:0]     rsp_l2_table_frame,
   input logic [ptw_pkg::FRAME_W-1:0]     rsp_data_frame,
   input logic [ptw_pkg::REF_W-1:0]       rsp_ref_count,
   input logic [ptw_pkg::CNT9_W-1:0]      rsp_proc_faults,
   input logic [ptw_pkg::CNT9_W-1:0]      rsp_frames_used
);
   import ptw_pkg::*;

   // stalled result keeps its valid, status, data frame and fault count
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_data_frame) && $stable(rsp_proc_faults))
      else $error("result changed while stalled");

   // a register write restarts the run and blocks requests
   a_csr_clear: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> !req_ready)
      else $error("request taken right after register write");

   // one walk at a time
   a_one_walk: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken during a walk");

   // halted results carry a zero l1 hit flag, l2 table frame, fault count and frames used
   a_halted_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_HALTED |->
      !rsp_l1_was_hit && rsp_l2_table_frame == '0 && rsp_proc_faults == '0 &&
      rsp_frames_used == '0)
      else $error("halted result with payload");

   // out of memory never reports a mapped page
   a_oom_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_OOM |->
      !rsp_l2_was_hit && rsp_data_frame == '0 && rsp_ref_count == '0)
      else $error("out of memory result with data frame");

endmodule

bind two_level_page_table_walker ptw_checker u_ptw_checker (
   .clock              (clock),
   .reset              (reset),
   .csr_we             (csr_we),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_status         (rsp_status),
   .rsp_l1_was_hit     (rsp_l1_was_hit),
   .rsp_l2_was_hit     (rsp_l2_was_hit),
   .rsp_l2_table_frame (rsp_l2_table_frame),
   .rsp_data_frame     (rsp_data_frame),
   .rsp_ref_count      (rsp_ref_count),
   .rsp_proc_faults    (rsp_proc_faults),
   .rsp_frames_used    (rsp_frames_used)
);
